>>> rtl/core/sdra_pkg.sv
// Shared constants, types and a helper function for the space-depth reorder address block.
`default_nettype none

package sdra_pkg;

    // Field and register widths.
    localparam int STRIDE_W     = 4;
    localparam int DIM_W        = 11;
    localparam int POS_W        = 10;
    localparam int SUB_W        = 3;
    localparam int TILE_W       = 6;
    localparam int SIDE_OUT_W   = 14;
    localparam int CH_OUT_W     = 17;
    localparam int DATA_W       = 32;
    localparam int DEST_W       = 30;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 11;

    // Limits of the supported geometry.
    localparam int MAX_STRIDE   = 8;
    localparam int MAX_CHANNELS = 1024;
    localparam int MAX_SIDE     = 1024;

    // Iterative divider sizing: dividend is a clamped dimension, divisor is s or s*s.
    localparam int QUOT_W       = DIM_W;
    localparam int DIVR_W       = 7;
    localparam int DIV_CNT_W    = $clog2(QUOT_W);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TILE_STRIDE  = 3'd0,
        REG_REVERSE_MODE = 3'd1,
        REG_IN_CHANNELS  = 3'd2,
        REG_IN_HEIGHT    = 3'd3,
        REG_IN_WIDTH     = 3'd4
    } cfg_reg_t;

    // Which dimension the shared divider is working on.
    typedef enum logic [1:0] {
        DIV_WIDTH  = 2'd0,
        DIV_HEIGHT = 2'd1,
        DIV_CHAN   = 2'd2
    } div_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     dirty_clr;
        logic     div_start;
        div_sel_t div_sel;
        logic     div_latch;
        logic     geom_load;
        logic     capture;
        logic     step_a;
        logic     step_b;
        logic     step_c;
        logic     out_load;
    } sdra_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dirty;
        logic div_busy;
        logic div_done;
        logic out_busy;
    } sdra_status_t;

    // A dimension of zero counts as one, anything above the limit saturates.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
            begin
                r = DIM_W'(1);
            end
            else if (v > maxv)
            begin
                r = maxv;
            end
            else
            begin
                r = v;
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/sdra_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module sdra_div
    import sdra_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [QUOT_W-1:0] dividend,
    input  wire logic [DIVR_W-1:0] divisor,
    output logic                   busy,
    output logic                   done,
    output logic [QUOT_W-1:0]      quotient,
    output logic [DIVR_W-1:0]      remainder
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(QUOT_W - 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [QUOT_W-1:0]    quo_reg, quo_next;
    logic [DIVR_W-1:0]    rem_reg, rem_next;
    logic [DIVR_W-1:0]    divisor_reg, divisor_next;
    logic [DIVR_W:0]      trial;
    logic                 fits;

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_reg, quo_reg[QUOT_W-1]};
    assign fits  = (trial >= {1'b0, divisor_reg});

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            quo_next     = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[QUOT_W-2:0], fits};
            rem_next = fits ? DIVR_W'(trial - {1'b0, divisor_reg}) : DIVR_W'(trial);
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> rtl/core/sdra_datapath.sv
// Datapath: configuration registers, scan counters, index arithmetic and output register.
`default_nettype none

module sdra_datapath
    import sdra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic [DATA_W-1:0]     elem_value,
    input  wire sdra_cmd_t             cmd,
    output sdra_status_t               status,
    input  wire logic                  out_ready,
    output logic                       out_valid,
    output logic [DEST_W-1:0]          dest_index,
    output logic [DATA_W-1:0]          out_value,
    output logic                       map_last,
    output logic                       config_error
);

    // Configuration registers.
    logic [STRIDE_W-1:0] stride_reg;
    logic                reverse_reg;
    logic [DIM_W-1:0]    chan_cfg_reg;
    logic [DIM_W-1:0]    height_cfg_reg;
    logic [DIM_W-1:0]    width_cfg_reg;
    logic                dirty_reg;
    logic                cfg_hit;

    // Effective geometry.
    logic [STRIDE_W-1:0] s_eff;
    logic                stride_bad;
    logic [DIM_W-1:0]    c_dim, h_dim, w_dim;
    logic [DIVR_W-1:0]   sq;

    // Divider results kept for the whole map.
    div_sel_t            div_sel_reg;
    logic [QUOT_W-1:0]   wq_reg, hq_reg, cq_reg;
    logic                wrem_nz_reg, hrem_nz_reg, crem_nz_reg;
    logic                err_reg;
    logic [SIDE_OUT_W-1:0] oh_reg, ow_reg;

    logic [QUOT_W-1:0]   div_dividend;
    logic [DIVR_W-1:0]   div_divisor;
    logic                div_busy, div_done;
    logic [QUOT_W-1:0]   div_quo;
    logic [DIVR_W-1:0]   div_rem;

    // Scan counters and their divided forms.
    logic [POS_W-1:0] x_reg, x_next, y_reg, y_next, c_reg, c_next;
    logic [SUB_W-1:0] xsub_reg, xsub_next, ysub_reg, ysub_next;
    logic [POS_W-1:0] xt_reg, xt_next, yt_reg, yt_next;
    logic [POS_W-1:0] cm_reg, cm_next;
    logic [SUB_W-1:0] gsub_reg, gsub_next, gt_reg, gt_next;
    logic             x_wrap, y_wrap, c_wrap, xsub_wrap, ysub_wrap, cm_wrap, gsub_wrap;

    // Pipeline registers.
    logic [DATA_W-1:0]     value_reg;
    logic [TILE_W-1:0]     tile_reg;
    logic [SIDE_OUT_W-1:0] ox_reg, oy_reg;
    logic [POS_W-1:0]      chan_a_reg;
    logic                  last_reg;
    logic [CH_OUT_W-1:0]   oc_reg;
    logic [DEST_W-1:0]     t_reg;

    // Output register.
    logic                  out_valid_reg;
    logic [DEST_W-1:0]     dest_reg;
    logic [DATA_W-1:0]     out_value_reg;
    logic                  map_last_reg;
    logic                  config_error_reg;

    // A write to a listed register restarts the map.
    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_TILE_STRIDE, REG_REVERSE_MODE, REG_IN_CHANNELS,
                REG_IN_HEIGHT, REG_IN_WIDTH: cfg_hit = 1'b1;
                default:                     cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg     <= STRIDE_W'(2);
            reverse_reg    <= 1'b0;
            chan_cfg_reg   <= DIM_W'(1);
            height_cfg_reg <= DIM_W'(1);
            width_cfg_reg  <= DIM_W'(1);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_TILE_STRIDE:  stride_reg     <= cfg_data[STRIDE_W-1:0];
                REG_REVERSE_MODE: reverse_reg    <= cfg_data[0];
                REG_IN_CHANNELS:  chan_cfg_reg   <= cfg_data[DIM_W-1:0];
                REG_IN_HEIGHT:    height_cfg_reg <= cfg_data[DIM_W-1:0];
                REG_IN_WIDTH:     width_cfg_reg  <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    // The setup pass must run again after reset and after any write to a listed register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg <= 1'b1;
        end
        else if (cfg_hit)
        begin
            dirty_reg <= 1'b1;
        end
        else if (cmd.dirty_clr)
        begin
            dirty_reg <= 1'b0;
        end
    end

    // Clamp stride and dimensions into the supported range.
    always_comb
    begin
        stride_bad = (stride_reg == '0) || (stride_reg > STRIDE_W'(MAX_STRIDE));
        if (stride_reg == '0)
        begin
            s_eff = STRIDE_W'(1);
        end
        else if (stride_reg > STRIDE_W'(MAX_STRIDE))
        begin
            s_eff = STRIDE_W'(MAX_STRIDE);
        end
        else
        begin
            s_eff = stride_reg;
        end
    end

    assign c_dim = clamp_dim(chan_cfg_reg, DIM_W'(MAX_CHANNELS));
    assign h_dim = clamp_dim(height_cfg_reg, DIM_W'(MAX_SIDE));
    assign w_dim = clamp_dim(width_cfg_reg, DIM_W'(MAX_SIDE));
    assign sq    = DIVR_W'(s_eff) * DIVR_W'(s_eff);

    // Operand selection for the shared divider.
    always_comb
    begin
        case (cmd.div_sel)
            DIV_WIDTH:
            begin
                div_dividend = w_dim;
                div_divisor  = DIVR_W'(s_eff);
            end
            DIV_HEIGHT:
            begin
                div_dividend = h_dim;
                div_divisor  = DIVR_W'(s_eff);
            end
            DIV_CHAN:
            begin
                div_dividend = c_dim;
                div_divisor  = sq;
            end
            default:
            begin
                div_dividend = w_dim;
                div_divisor  = DIVR_W'(s_eff);
            end
        endcase
    end

    sdra_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Store each quotient and whether the division left a remainder.
    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_sel_reg <= cmd.div_sel;
        end
        if (cmd.div_latch)
        begin
            case (div_sel_reg)
                DIV_WIDTH:
                begin
                    wq_reg      <= div_quo;
                    wrem_nz_reg <= (div_rem != '0);
                end
                DIV_HEIGHT:
                begin
                    hq_reg      <= div_quo;
                    hrem_nz_reg <= (div_rem != '0);
                end
                DIV_CHAN:
                begin
                    cq_reg      <= div_quo;
                    crem_nz_reg <= (div_rem != '0);
                end
                default: ;
            endcase
        end
        if (cmd.geom_load)
        begin
            if (reverse_reg)
            begin
                err_reg <= stride_bad || crem_nz_reg;
                oh_reg  <= SIDE_OUT_W'(h_dim) * SIDE_OUT_W'(s_eff);
                ow_reg  <= SIDE_OUT_W'(w_dim) * SIDE_OUT_W'(s_eff);
            end
            else
            begin
                err_reg <= stride_bad || wrem_nz_reg || hrem_nz_reg;
                oh_reg  <= SIDE_OUT_W'(hq_reg);
                ow_reg  <= SIDE_OUT_W'(wq_reg);
            end
        end
    end

    // Wrap conditions of the scan position and its sub-counters.
    assign x_wrap    = (DIM_W'(x_reg) + DIM_W'(1)) >= w_dim;
    assign y_wrap    = (DIM_W'(y_reg) + DIM_W'(1)) >= h_dim;
    assign c_wrap    = (DIM_W'(c_reg) + DIM_W'(1)) >= c_dim;
    assign xsub_wrap = (STRIDE_W'(xsub_reg) + STRIDE_W'(1)) >= s_eff;
    assign ysub_wrap = (STRIDE_W'(ysub_reg) + STRIDE_W'(1)) >= s_eff;
    assign gsub_wrap = (STRIDE_W'(gsub_reg) + STRIDE_W'(1)) >= s_eff;
    assign cm_wrap   = (DIM_W'(cm_reg) + DIM_W'(1)) >= cq_reg;

    // Advance the scan in column, row, channel order.
    always_comb
    begin
        x_next    = x_reg;
        xsub_next = xsub_reg;
        xt_next   = xt_reg;
        y_next    = y_reg;
        ysub_next = ysub_reg;
        yt_next   = yt_reg;
        c_next    = c_reg;
        cm_next   = cm_reg;
        gsub_next = gsub_reg;
        gt_next   = gt_reg;
        if (cfg_hit)
        begin
            x_next    = '0;
            xsub_next = '0;
            xt_next   = '0;
            y_next    = '0;
            ysub_next = '0;
            yt_next   = '0;
            c_next    = '0;
            cm_next   = '0;
            gsub_next = '0;
            gt_next   = '0;
        end
        else if (cmd.step_a)
        begin
            if (x_wrap)
            begin
                x_next    = '0;
                xsub_next = '0;
                xt_next   = '0;
                if (y_wrap)
                begin
                    y_next    = '0;
                    ysub_next = '0;
                    yt_next   = '0;
                    if (c_wrap)
                    begin
                        c_next    = '0;
                        cm_next   = '0;
                        gsub_next = '0;
                        gt_next   = '0;
                    end
                    else
                    begin
                        c_next = c_reg + POS_W'(1);
                        if (cm_wrap)
                        begin
                            cm_next = '0;
                            if (gsub_wrap)
                            begin
                                gsub_next = '0;
                                gt_next   = gt_reg + SUB_W'(1);
                            end
                            else
                            begin
                                gsub_next = gsub_reg + SUB_W'(1);
                            end
                        end
                        else
                        begin
                            cm_next = cm_reg + POS_W'(1);
                        end
                    end
                end
                else
                begin
                    y_next = y_reg + POS_W'(1);
                    if (ysub_wrap)
                    begin
                        ysub_next = '0;
                        yt_next   = yt_reg + POS_W'(1);
                    end
                    else
                    begin
                        ysub_next = ysub_reg + SUB_W'(1);
                    end
                end
            end
            else
            begin
                x_next = x_reg + POS_W'(1);
                if (xsub_wrap)
                begin
                    xsub_next = '0;
                    xt_next   = xt_reg + POS_W'(1);
                end
                else
                begin
                    xsub_next = xsub_reg + SUB_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            xsub_reg <= '0;
            xt_reg   <= '0;
            y_reg    <= '0;
            ysub_reg <= '0;
            yt_reg   <= '0;
            c_reg    <= '0;
            cm_reg   <= '0;
            gsub_reg <= '0;
            gt_reg   <= '0;
        end
        else
        begin
            x_reg    <= x_next;
            xsub_reg <= xsub_next;
            xt_reg   <= xt_next;
            y_reg    <= y_next;
            ysub_reg <= ysub_next;
            yt_reg   <= yt_next;
            c_reg    <= c_next;
            cm_reg   <= cm_next;
            gsub_reg <= gsub_next;
            gt_reg   <= gt_next;
        end
    end

    // Index pipeline: output coordinates, then channel, then two multiply-adds.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            value_reg <= elem_value;
        end
        if (cmd.step_a)
        begin
            tile_reg <= TILE_W'(ysub_reg) * TILE_W'(s_eff) + TILE_W'(xsub_reg);
            last_reg <= x_wrap && y_wrap && c_wrap;
            if (reverse_reg)
            begin
                ox_reg     <= SIDE_OUT_W'(x_reg) * SIDE_OUT_W'(s_eff) + SIDE_OUT_W'(gsub_reg);
                oy_reg     <= SIDE_OUT_W'(y_reg) * SIDE_OUT_W'(s_eff) + SIDE_OUT_W'(gt_reg);
                chan_a_reg <= cm_reg;
            end
            else
            begin
                ox_reg     <= SIDE_OUT_W'(xt_reg);
                oy_reg     <= SIDE_OUT_W'(yt_reg);
                chan_a_reg <= c_reg;
            end
        end
        if (cmd.step_b)
        begin
            if (reverse_reg)
            begin
                oc_reg <= CH_OUT_W'(chan_a_reg);
            end
            else
            begin
                oc_reg <= CH_OUT_W'(tile_reg) * CH_OUT_W'(c_dim) + CH_OUT_W'(chan_a_reg);
            end
        end
        if (cmd.step_c)
        begin
            t_reg <= DEST_W'(oc_reg) * DEST_W'(oh_reg) + DEST_W'(oy_reg);
        end
    end

    // Output register: holds a finished result until it is transferred.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            dest_reg         <= err_reg ? '0 : (t_reg * DEST_W'(ow_reg) + DEST_W'(ox_reg));
            out_value_reg    <= value_reg;
            map_last_reg     <= last_reg;
            config_error_reg <= err_reg;
        end
    end

    assign status.dirty    = dirty_reg;
    assign status.div_busy = div_busy;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;

    assign out_valid    = out_valid_reg;
    assign dest_index   = dest_reg;
    assign out_value    = out_value_reg;
    assign map_last     = map_last_reg;
    assign config_error = config_error_reg;

endmodule

`default_nettype wire

>>> rtl/core/sdra_ctrl.sv
// Controller state machine: setup divisions after configuration, then per-element sequencing.
`default_nettype none

module sdra_ctrl
    import sdra_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire sdra_status_t status,
    output sdra_cmd_t         cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_DIV_W = 9'b000000010,
        ST_DIV_H = 9'b000000100,
        ST_DIV_C = 9'b000001000,
        ST_GEOM  = 9'b000010000,
        ST_A     = 9'b000100000,
        ST_B     = 9'b001000000,
        ST_C     = 9'b010000000,
        ST_D     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE) && !status.dirty;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_WIDTH;
        case (state_reg)
            ST_IDLE:
            begin
                if (status.dirty)
                begin
                    cmd.dirty_clr = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_WIDTH;
                    state_next    = ST_DIV_W;
                end
                else if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_A;
                end
            end
            ST_DIV_W:
            begin
                if (status.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_HEIGHT;
                    state_next    = ST_DIV_H;
                end
            end
            ST_DIV_H:
            begin
                if (status.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = DIV_CHAN;
                    state_next    = ST_DIV_C;
                end
            end
            ST_DIV_C:
            begin
                if (status.div_done)
                begin
                    cmd.div_latch = 1'b1;
                    state_next    = ST_GEOM;
                end
            end
            ST_GEOM:
            begin
                cmd.geom_load = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_A:
            begin
                cmd.step_a = 1'b1;
                state_next = ST_B;
            end
            ST_B:
            begin
                cmd.step_b = 1'b1;
                state_next = ST_C;
            end
            ST_C:
            begin
                cmd.step_c = 1'b1;
                state_next = ST_D;
            end
            ST_D:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // The divider is only started when it has finished its previous job.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !status.div_busy)
        else $error("divider started while busy");

    // No element is taken while a setup division is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.div_busy |-> !in_ready)
        else $error("input ready during setup division");

    // A division result is stored only right after the divider has worked.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_latch |-> $past(status.div_busy))
        else $error("division result stored without a finished division");

endmodule

`default_nettype wire

>>> rtl/core/space_depth_reorder_address.sv
// Top level of the space-to-depth / depth-to-space address generator.
//
// Elements of one feature map arrive in channel, row, column order; each leaves with its
// linear index in the reorganized map (space to depth when reverse_mode is 0, depth to
// space when it is 1), its data word unchanged, a last-element mark and a configuration
// error flag. Each element passes through a coordinate stage, a channel stage, one
// multiply-add stage, then a second multiply-add into the output register; the block
// takes no new element until the previous one has been loaded into the output register,
// and a stalled output holds the following element in its final stage.
// After reset and after any write to a mapped register the block first runs a setup pass,
// three 11-bit divisions on one shared bit-serial divider, and takes no element
// until it ends. A write to a mapped register restarts the map.
`default_nettype none

module space_depth_reorder_address
    import sdra_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [DATA_W-1:0]     elem_value,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [DEST_W-1:0]          dest_index,
    output logic [DATA_W-1:0]          out_value,
    output logic                       map_last,
    output logic                       config_error
);

    sdra_cmd_t    cmd;
    sdra_status_t status;

    // Sequencing of setup and element transfers.
    sdra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Counters, index arithmetic and result register.
    sdra_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .elem_value   (elem_value),
        .cmd          (cmd),
        .status       (status),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .dest_index   (dest_index),
        .out_value    (out_value),
        .map_last     (map_last),
        .config_error (config_error)
    );

endmodule

`default_nettype wire

>>> verif/tb_space_depth_reorder_address.sv
// Testbench for the space-to-depth / depth-to-space reorder address generator.
`default_nettype none

module tb_space_depth_reorder_address
    import sdra_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes past the end of the register list; writes there are dropped.
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] UNMAPPED_REG_HI = 3'd7;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int RANDOM_ITEMS = 140;

    // One expected output transfer.
    typedef struct {
        logic [DEST_W-1:0] dest;
        logic [DATA_W-1:0] value;
        logic              last;
        logic              err;
    } reorder_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [DATA_W-1:0]     elem_value;
    logic                  out_valid;
    logic                  out_ready;
    logic [DEST_W-1:0]     dest_index;
    logic [DATA_W-1:0]     out_value;
    logic                  map_last;
    logic                  config_error;

    // Register copies and scan position kept by the predictor.
    logic [STRIDE_W-1:0]   cur_stride;
    logic                  cur_reverse;
    logic [DIM_W-1:0]      cur_chans;
    logic [DIM_W-1:0]      cur_rows;
    logic [DIM_W-1:0]      cur_cols;
    int unsigned           scan_chan;
    int unsigned           scan_row;
    int unsigned           scan_col;

    reorder_result_t       pending_results[$];
    int                    fail_count;
    int                    cycle_count;
    int unsigned           send_idle_pct;
    int unsigned           recv_idle_pct;

    space_depth_reorder_address dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .elem_value   (elem_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .dest_index   (dest_index),
        .out_value    (out_value),
        .map_last     (map_last),
        .config_error (config_error)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Zero counts as one and anything above the limit saturates.
    function automatic longint unsigned saturate_dim(input logic [DIM_W-1:0] v,
                                                     input int unsigned maxv);
        longint unsigned r;
        begin
            r = v;
            if (r == 0)
            begin
                r = 1;
            end
            else if (r > maxv)
            begin
                r = maxv;
            end
            return r;
        end
    endfunction

    // Works out the destination of the element at the current scan position and
    // moves the scan position on by one element.
    function automatic reorder_result_t predict_reorder(input logic [DATA_W-1:0] v);
        reorder_result_t r;
        longint unsigned s;
        longint unsigned chans;
        longint unsigned rows;
        longint unsigned cols;
        longint unsigned c;
        longint unsigned y;
        longint unsigned x;
        longint unsigned dest;
        longint unsigned grp_chans;
        longint unsigned grp;
        longint unsigned oc;
        longint unsigned oy;
        longint unsigned ox;
        longint unsigned oh;
        longint unsigned ow;
        bit              err;
        begin
            s     = cur_stride;
            err   = 1'b0;
            chans = saturate_dim(cur_chans, MAX_CHANNELS);
            rows  = saturate_dim(cur_rows, MAX_SIDE);
            cols  = saturate_dim(cur_cols, MAX_SIDE);
            c     = scan_chan;
            y     = scan_row;
            x     = scan_col;
            dest  = 0;

            // An unusable stride is replaced and flagged.
            if (s == 0)
            begin
                s   = 1;
                err = 1'b1;
            end
            if (s > MAX_STRIDE)
            begin
                s   = MAX_STRIDE;
                err = 1'b1;
            end

            if (!cur_reverse)
            begin
                // Space to depth: each tile position becomes a channel group.
                if ((cols % s) != 0 || (rows % s) != 0)
                begin
                    err = 1'b1;
                end
                if (!err)
                begin
                    oh   = rows / s;
                    ow   = cols / s;
                    ox   = x / s;
                    oy   = y / s;
                    oc   = ((y % s) * s + (x % s)) * chans + c;
                    dest = (oc * oh + oy) * ow + ox;
                end
            end
            else
            begin
                // Depth to space: each channel group lands on one tile position.
                if ((chans % (s * s)) != 0)
                begin
                    err = 1'b1;
                end
                if (!err)
                begin
                    grp_chans = chans / (s * s);
                    oh        = rows * s;
                    ow        = cols * s;
                    grp       = c / grp_chans;
                    ox        = x * s + (grp % s);
                    oy        = y * s + (grp / s);
                    oc        = c % grp_chans;
                    dest      = (oc * oh + oy) * ow + ox;
                end
            end

            r.dest  = err ? '0 : dest[DEST_W-1:0];
            r.value = v;
            r.last  = (c + 1 >= chans) && (y + 1 >= rows) && (x + 1 >= cols);
            r.err   = err;

            // Column, then row, then channel; everything wraps at the end of the map.
            if (x + 1 >= cols)
            begin
                scan_col = 0;
                if (y + 1 >= rows)
                begin
                    scan_row  = 0;
                    scan_chan = (c + 1 >= chans) ? 0 : int'(c + 1);
                end
                else
                begin
                    scan_row = int'(y + 1);
                end
            end
            else
            begin
                scan_col = int'(x + 1);
            end
            return r;
        end
    endfunction

    // Drops the input valid and waits until every expected result has come out.
    task automatic wait_idle();
        begin
            @(negedge clk);
            in_valid = 1'b0;
            while (pending_results.size() != 0)
            begin
                @(posedge clk);
            end
        end
    endtask

    // Writes one register once the block is idle and mirrors a mapped write in the predictor.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        begin
            wait_idle();
            @(negedge clk);
            cfg_write = 1'b1;
            cfg_index = idx;
            cfg_data  = data;
            @(negedge clk);
            cfg_write = 1'b0;
            if (idx <= REG_IN_WIDTH)
            begin
                case (idx)
                    REG_TILE_STRIDE:  cur_stride  = data[STRIDE_W-1:0];
                    REG_REVERSE_MODE: cur_reverse = data[0];
                    REG_IN_CHANNELS:  cur_chans   = data[DIM_W-1:0];
                    REG_IN_HEIGHT:    cur_rows    = data[DIM_W-1:0];
                    default:          cur_cols    = data[DIM_W-1:0];
                endcase
                // Any mapped write restarts the map.
                scan_chan = 0;
                scan_row  = 0;
                scan_col  = 0;
            end
        end
    endtask

    // Writes all five registers in list order.
    task automatic set_map(input logic [CFG_DATA_W-1:0] stride, input logic rev,
                           input logic [CFG_DATA_W-1:0] chans,
                           input logic [CFG_DATA_W-1:0] rows,
                           input logic [CFG_DATA_W-1:0] cols);
        begin
            write_reg(REG_TILE_STRIDE, stride);
            write_reg(REG_REVERSE_MODE, CFG_DATA_W'(rev));
            write_reg(REG_IN_CHANNELS, chans);
            write_reg(REG_IN_HEIGHT, rows);
            write_reg(REG_IN_WIDTH, cols);
        end
    endtask

    // Sends one element; returns at the edge where the transfer happens.
    task automatic send_elem(input logic [DATA_W-1:0] v);
        begin
            @(negedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
            in_valid   = 1'b1;
            elem_value = v;
            @(posedge clk);
            while (!in_ready)
            begin
                @(posedge clk);
            end
            pending_results.push_back(predict_reorder(v));
        end
    endtask

    // Output side: ready drops at random according to the current idle rate.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compares each output transfer with the oldest expectation.
    always @(posedge clk)
    begin
        reorder_result_t exp_res;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: dest_index %0d out_value %h", dest_index, out_value);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (dest_index !== exp_res.dest)
                begin
                    $error("dest_index: expected %0d, actual %0d", exp_res.dest, dest_index);
                    fail_count++;
                end
                if (out_value !== exp_res.value)
                begin
                    $error("out_value: expected %h, actual %h", exp_res.value, out_value);
                    fail_count++;
                end
                if (map_last !== exp_res.last)
                begin
                    $error("map_last: expected %0b, actual %0b", exp_res.last, map_last);
                    fail_count++;
                end
                if (config_error !== exp_res.err)
                begin
                    $error("config_error: expected %0b, actual %0b", exp_res.err, config_error);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Reset values leave a 1x1x1 map with stride 2, which cannot be folded.
    task automatic test_reset_defaults();
        begin
            send_elem(32'h0000_0000);
            send_elem(32'hFFFF_FFFF);
        end
    endtask

    // Forward fold of one 2x2 tile into four channels.
    task automatic test_forward_fold();
        begin
            set_map(11'd2, 1'b0, 11'd1, 11'd2, 11'd2);
            send_elem(32'hA5A5_A5A5);
            send_elem(32'h5A5A_5A5A);
            send_elem(32'h0123_4567);
            send_elem(32'h89AB_CDEF);
        end
    endtask

    // Reverse spread of four channels back into one 2x2 tile.
    task automatic test_reverse_spread();
        begin
            set_map(11'd2, 1'b1, 11'd4, 11'd1, 11'd1);
            repeat (4)
            begin
                send_elem($urandom);
            end
        end
    endtask

    // Stride zero, stride above the limit, and upper data bits that the register drops.
    task automatic test_stride_out_of_range();
        begin
            set_map(11'd0, 1'b0, 11'd1, 11'd2, 11'd2);
            send_elem($urandom);
            write_reg(REG_TILE_STRIDE, 11'h7FF);
            send_elem($urandom);
            write_reg(REG_TILE_STRIDE, 11'd9);
            send_elem($urandom);
        end
    endtask

    // Dimensions that the stride does not divide, in both directions.
    task automatic test_not_divisible();
        begin
            set_map(11'd3, 1'b0, 11'd1, 11'd4, 11'd3);
            send_elem($urandom);
            set_map(11'd2, 1'b1, 11'd2, 11'd1, 11'd1);
            send_elem($urandom);
        end
    endtask

    // Zero and saturated dimensions, and the largest map at the largest stride.
    task automatic test_dimension_limits();
        begin
            set_map(11'd1, 1'b0, 11'd0, 11'd0, 11'd2047);
            send_elem($urandom);
            send_elem($urandom);
            set_map(11'd8, 1'b0, 11'd1024, 11'd1024, 11'd1024);
            send_elem($urandom);
            send_elem($urandom);
            write_reg(REG_REVERSE_MODE, 11'h7FF);
            send_elem($urandom);
        end
    endtask

    // Writes past the register list neither take effect nor restart the map.
    task automatic test_unmapped_index();
        logic [CFG_IDX_W-1:0] idx;
        begin
            set_map(11'd1, 1'b0, 11'd1, 11'd1, 11'd3);
            send_elem($urandom);
            for (idx = UNMAPPED_REG_LO; idx <= UNMAPPED_REG_HI; idx++)
            begin
                write_reg(idx, CFG_DATA_W'($urandom_range(0, 2047)));
                if (idx == UNMAPPED_REG_HI)
                begin
                    break;
                end
            end
            send_elem($urandom);
            send_elem($urandom);
        end
    endtask

    // Picks a map: mostly usable geometries small enough to wrap, some raw noise.
    task automatic pick_map_config();
        logic [CFG_DATA_W-1:0] stride;
        logic [CFG_DATA_W-1:0] chans;
        logic [CFG_DATA_W-1:0] rows;
        logic [CFG_DATA_W-1:0] cols;
        logic                  rev;
        begin
            rev = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 20)
            begin
                stride = CFG_DATA_W'($urandom_range(0, 2047));
                chans  = CFG_DATA_W'($urandom_range(0, 2047));
                rows   = CFG_DATA_W'($urandom_range(0, 2047));
                cols   = CFG_DATA_W'($urandom_range(0, 2047));
            end
            else if (!rev)
            begin
                stride = CFG_DATA_W'($urandom_range(1, MAX_STRIDE));
                chans  = CFG_DATA_W'($urandom_range(1, 3));
                rows   = CFG_DATA_W'(stride * $urandom_range(1, 2));
                cols   = CFG_DATA_W'(stride * $urandom_range(1, 2));
            end
            else
            begin
                stride = CFG_DATA_W'($urandom_range(1, 4));
                chans  = CFG_DATA_W'(stride * stride * $urandom_range(1, 2));
                rows   = CFG_DATA_W'($urandom_range(1, 3));
                cols   = CFG_DATA_W'($urandom_range(1, 3));
            end
            set_map(stride, rev, chans, rows, cols);
        end
    endtask

    // Runs random maps with random data until the item budget is spent.
    task automatic run_random_maps(input int items);
        int sent;
        int burst;
        begin
            sent = 0;
            while (sent < items)
            begin
                pick_map_config();
                burst = $urandom_range(8, 40);
                if (burst > items - sent)
                begin
                    burst = items - sent;
                end
                repeat (burst)
                begin
                    send_elem($urandom);
                end
                sent += burst;
            end
        end
    endtask

    task automatic test_random_output_stalls();
        begin
            send_idle_pct = 11;
            recv_idle_pct = 49;
            run_random_maps(RANDOM_ITEMS);
        end
    endtask

    task automatic test_random_input_gaps();
        begin
            send_idle_pct = 49;
            recv_idle_pct = 11;
            run_random_maps(RANDOM_ITEMS);
        end
    endtask

    task automatic test_random_full_rate();
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
            run_random_maps(RANDOM_ITEMS);
        end
    endtask

    // Reset, directed cases, random phases, then drain and report.
    initial
    begin
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        elem_value    = '0;
        fail_count    = 0;
        cycle_count   = 0;
        send_idle_pct = 11;
        recv_idle_pct = 49;
        cur_stride    = 4'd2;
        cur_reverse   = 1'b0;
        cur_chans     = 11'd1;
        cur_rows      = 11'd1;
        cur_cols      = 11'd1;
        scan_chan     = 0;
        scan_row      = 0;
        scan_col      = 0;
        repeat (5)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_defaults();
        test_forward_fold();
        test_reverse_spread();
        test_stride_out_of_range();
        test_not_divisible();
        test_dimension_limits();
        test_unmapped_index();
        test_random_output_stalls();
        test_random_input_gaps();
        test_random_full_rate();

        wait_idle();
        repeat (20)
        begin
            @(posedge clk);
        end
        if (fail_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> space_depth_reorder_address.f
rtl/core/sdra_pkg.sv
rtl/core/sdra_div.sv
rtl/core/sdra_datapath.sv
rtl/core/sdra_ctrl.sv
rtl/core/space_depth_reorder_address.sv
verif/tb_space_depth_reorder_address.sv
